### design/srsw_pkg.sv
// Shared types, constants and control-word encoding for the selective-repeat sender window.
package srsw_pkg;

  // Sizes
  localparam int MAX_WINDOW  = 64;
  localparam int SLOT_W      = $clog2(MAX_WINDOW);
  localparam int CNT_W       = SLOT_W + 1;
  localparam int WIN_W       = 7;
  localparam int PKT_W       = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 1;
  localparam int STEP_W      = 4;

  // Register indexes of the config port
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_SIZE   = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TOTAL_PACKETS = 1'd1;

  localparam logic [WIN_W-1:0] WINDOW_RESET = 7'd4;

  // Command codes
  localparam logic CMD_BUILD = 1'b0;
  localparam logic CMD_ACK   = 1'b1;

  // Input word
  typedef struct packed {
    logic                  command;
    logic [MAX_WINDOW-1:0] nak_mask;
  } in_item_t;

  // Result word
  typedef struct packed {
    logic [PKT_W-1:0] packet_number;
    logic             is_retransmit;
    logic [PKT_W-1:0] frame_number;
    logic             frame_empty;
    logic [CNT_W-1:0] nak_count;
    logic             all_positive;
    logic             all_done;
    logic             last;
  } result_t;

  // Datapath operations selected by the microcode
  typedef enum logic [3:0] {
    OP_NOP,
    OP_WAIT,
    OP_B_PREP,
    OP_B_SIZE,
    OP_B_SLOT,
    OP_B_FIN,
    OP_B_EMPTY,
    OP_A_PREP,
    OP_A_SIZE,
    OP_A_SCAN,
    OP_A_FIN
  } op_t;

  // Next-step selection
  typedef enum logic [2:0] {
    C_NEXT,
    C_JUMP,
    C_START,
    C_ZERO,
    C_LOOP
  } cond_t;

  typedef logic [STEP_W-1:0] step_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_word_t;

  // Flags from datapath to sequencer
  typedef struct packed {
    logic zero;
    logic more;
  } status_t;

endpackage

### design/srsw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module srsw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### design/srsw_seq.sv
// Microcode sequencer: step counter, control ROM and jump logic.
module srsw_seq import srsw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       command,
  input  status_t    status,
  output ctrl_word_t ctrl,
  output logic       busy
);

  // Program addresses
  localparam step_t S_IDLE    = 4'd0;
  localparam step_t S_B_PREP  = 4'd1;
  localparam step_t S_B_SIZE  = 4'd2;
  localparam step_t S_B_SLOT  = 4'd3;
  localparam step_t S_B_DRAIN = 4'd4;
  localparam step_t S_B_FIN   = 4'd5;
  localparam step_t S_B_EMPTY = 4'd6;
  localparam step_t S_A_PREP  = 4'd7;
  localparam step_t S_A_SIZE  = 4'd8;
  localparam step_t S_A_SCAN  = 4'd9;
  localparam step_t S_A_DRAIN = 4'd10;
  localparam step_t S_A_FIN   = 4'd11;

  step_t pc;
  step_t pc_next;
  step_t pc_inc;

  assign pc_inc = pc + STEP_W'(1);

  // Control ROM
  always_comb begin
    case (pc)
      S_IDLE:    ctrl = '{op: OP_WAIT,    cond: C_START, target: S_A_PREP};
      S_B_PREP:  ctrl = '{op: OP_B_PREP,  cond: C_NEXT,  target: S_IDLE};
      S_B_SIZE:  ctrl = '{op: OP_B_SIZE,  cond: C_ZERO,  target: S_B_EMPTY};
      S_B_SLOT:  ctrl = '{op: OP_B_SLOT,  cond: C_LOOP,  target: S_IDLE};
      S_B_DRAIN: ctrl = '{op: OP_NOP,     cond: C_NEXT,  target: S_IDLE};
      S_B_FIN:   ctrl = '{op: OP_B_FIN,   cond: C_JUMP,  target: S_IDLE};
      S_B_EMPTY: ctrl = '{op: OP_B_EMPTY, cond: C_JUMP,  target: S_IDLE};
      S_A_PREP:  ctrl = '{op: OP_A_PREP,  cond: C_NEXT,  target: S_IDLE};
      S_A_SIZE:  ctrl = '{op: OP_A_SIZE,  cond: C_ZERO,  target: S_A_FIN};
      S_A_SCAN:  ctrl = '{op: OP_A_SCAN,  cond: C_LOOP,  target: S_IDLE};
      S_A_DRAIN: ctrl = '{op: OP_NOP,     cond: C_NEXT,  target: S_IDLE};
      S_A_FIN:   ctrl = '{op: OP_A_FIN,   cond: C_JUMP,  target: S_IDLE};
      default:   ctrl = '{op: OP_NOP,     cond: C_JUMP,  target: S_IDLE};
    endcase
  end

  // Next step
  always_comb begin
    case (ctrl.cond)
      C_NEXT:  pc_next = pc_inc;
      C_JUMP:  pc_next = ctrl.target;
      C_START: begin
        if (start) begin
          pc_next = (command == CMD_ACK) ? ctrl.target : pc_inc;
        end else begin
          pc_next = pc;
        end
      end
      C_ZERO:  pc_next = status.zero ? ctrl.target : pc_inc;
      C_LOOP:  pc_next = status.more ? pc : pc_inc;
      default: pc_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  assign busy = (pc != S_IDLE);

endmodule

### design/srsw_dp.sv
// Datapath: config registers, window counters, frame and resend stores, result word.
module srsw_dp import srsw_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  in_item_t               item,
  input  op_t                    op,
  input  logic                   wr_en,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic [CFG_DATA_W-1:0]  wr_data,
  output status_t                status,
  output logic                   strobe,
  output result_t                result
);

  // Config and session state
  logic [WIN_W-1:0]      window_size;
  logic [PKT_W-1:0]      total_packets;
  logic [PKT_W-1:0]      next_sequence;
  logic [PKT_W-1:0]      acked_count;
  logic [PKT_W-1:0]      frames_built;
  logic [CNT_W-1:0]      resend_count;
  logic [CNT_W-1:0]      frame_length;

  // Per-command working registers
  logic [MAX_WINDOW-1:0] nak_mask;
  logic [PKT_W-1:0]      avail;
  logic [CNT_W-1:0]      room;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      naks;
  logic [SLOT_W-1:0]     m;

  // Slot stage, lines up with the registered RAM read
  logic                  st_valid;
  logic                  st_ack;
  logic                  st_retx;
  logic                  st_last;
  logic                  st_nak;
  logic [SLOT_W-1:0]     st_m;
  logic [PKT_W-1:0]      st_seq;

  logic [CNT_W-1:0]      w_eff;
  logic [CNT_W-1:0]      fresh;
  logic [CNT_W-1:0]      bsize;
  logic [CNT_W-1:0]      m_inc;
  logic                  slot_resend;
  logic [PKT_W-1:0]      packet;
  logic [PKT_W-1:0]      rs_rdata;
  logic [PKT_W-1:0]      fs_rdata;
  logic                  rs_wr_en;
  logic                  fs_wr_en;

  // Clamp window to 1..MAX_WINDOW
  always_comb begin
    if (window_size == '0) begin
      w_eff = CNT_W'(1);
    end else if (window_size > WIN_W'(MAX_WINDOW)) begin
      w_eff = CNT_W'(MAX_WINDOW);
    end else begin
      w_eff = window_size;
    end
  end

  // Slot count = min(room, avail); room never exceeds the window
  assign fresh = (avail < {{(PKT_W-CNT_W){1'b0}}, room}) ? avail[CNT_W-1:0] : room;
  assign bsize = resend_count + fresh;
  assign m_inc = {1'b0, m} + CNT_W'(1);
  assign slot_resend = ({1'b0, m} < resend_count);

  assign status.zero = (op == OP_A_SIZE) ? (fresh == '0) : (bsize == '0);
  assign status.more = (m_inc != count);

  assign packet = st_retx ? rs_rdata : st_seq;

  // Config write port
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size   <= WINDOW_RESET;
      total_packets <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_WINDOW_SIZE:   window_size   <= wr_data[WIN_W-1:0];
        REG_TOTAL_PACKETS: total_packets <= wr_data[PKT_W-1:0];
        default: ;
      endcase
    end
  end

  // Session state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      next_sequence <= '0;
      acked_count   <= '0;
      frames_built  <= '0;
      resend_count  <= '0;
      frame_length  <= '0;
      st_valid      <= 1'b0;
    end else begin
      case (op)
        OP_B_SLOT: begin
          if (!slot_resend) begin
            next_sequence <= next_sequence + PKT_W'(1);
          end
        end
        OP_B_FIN: begin
          frames_built <= frames_built + PKT_W'(1);
          resend_count <= '0;
          frame_length <= count;
        end
        OP_B_EMPTY: begin
          resend_count <= '0;
          frame_length <= '0;
        end
        OP_A_FIN: begin
          resend_count <= naks;
          frame_length <= '0;
        end
        default: ;
      endcase
      if (st_valid && st_ack && !st_nak) begin
        acked_count <= acked_count + PKT_W'(1);
      end
      st_valid <= (op == OP_B_SLOT) || (op == OP_A_SCAN);
    end
  end

  // Working registers and slot stage payload
  always_ff @(posedge clk) begin
    case (op)
      OP_WAIT: begin
        if (start) begin
          nak_mask <= item.nak_mask;
        end
      end
      OP_B_PREP: begin
        avail <= (next_sequence < total_packets) ? (total_packets - next_sequence) : '0;
        room  <= (resend_count < w_eff) ? (w_eff - resend_count) : '0;
      end
      OP_B_SIZE: begin
        count <= bsize;
        m     <= '0;
      end
      OP_B_SLOT: begin
        m       <= m + SLOT_W'(1);
        st_ack  <= 1'b0;
        st_retx <= slot_resend;
        st_nak  <= 1'b0;
        st_last <= (m_inc == count);
        st_m    <= m;
        st_seq  <= next_sequence;
      end
      OP_A_PREP: begin
        avail <= (acked_count < total_packets) ? (total_packets - acked_count) : '0;
        room  <= (w_eff < frame_length) ? w_eff : frame_length;
        naks  <= '0;
      end
      OP_A_SIZE: begin
        count <= fresh;
        m     <= '0;
      end
      OP_A_SCAN: begin
        m       <= m + SLOT_W'(1);
        st_ack  <= 1'b1;
        st_retx <= 1'b0;
        st_nak  <= nak_mask[m];
        st_last <= 1'b0;
        st_m    <= m;
        st_seq  <= next_sequence;
      end
      default: ;
    endcase
    if (st_valid && st_ack && st_nak) begin
      naks <= naks + CNT_W'(1);
    end
  end

  // Build stage stores its slot, ack stage queues NAKed packets
  assign fs_wr_en = st_valid && !st_ack;
  assign rs_wr_en = st_valid && st_ack && st_nak;

  srsw_ram #(
    .WIDTH (PKT_W),
    .DEPTH (MAX_WINDOW)
  ) u_resend_list (
    .clk     (clk),
    .wr_en   (rs_wr_en),
    .wr_addr (naks[SLOT_W-1:0]),
    .wr_data (fs_rdata),
    .rd_addr (m),
    .rd_data (rs_rdata)
  );

  srsw_ram #(
    .WIDTH (PKT_W),
    .DEPTH (MAX_WINDOW)
  ) u_frame_store (
    .clk     (clk),
    .wr_en   (fs_wr_en),
    .wr_addr (st_m),
    .wr_data (packet),
    .rd_addr (m),
    .rd_data (fs_rdata)
  );

  // Result word
  always_comb begin
    strobe               = 1'b0;
    result               = '0;
    result.frame_number  = frames_built;
    result.all_done      = (acked_count >= total_packets);
    if (st_valid && !st_ack) begin
      strobe               = 1'b1;
      result.packet_number = packet;
      result.is_retransmit = st_retx;
      result.last          = st_last;
    end else if (op == OP_B_EMPTY) begin
      strobe             = 1'b1;
      result.frame_empty = 1'b1;
      result.last        = 1'b1;
    end else if (op == OP_A_FIN) begin
      strobe              = 1'b1;
      result.nak_count    = naks;
      result.all_positive = (naks == '0);
      result.last         = 1'b1;
    end
  end

endmodule

### design/selective_repeat_sender_window.sv
// Top level of the selective-repeat ARQ sender window.
// Usage:
//   A command word (item) is taken at a clock edge where start is high and busy
//   is low. Command build assembles the next frame: queued resends first, then
//   fresh sequence numbers up to the window or the session total. Each slot
//   appears on result for one cycle with strobe high; the last slot has last set.
//   A build with nothing to send gives one word with frame_empty set.
//   Command ack walks the stored frame against nak_mask and gives one summary word.
// The microcode program walks one slot per cycle through the frame and resend
// RAMs (registered read). A build steps through prepare, size, slot loop, drain
// and finish, with one result word per cycle from the slot loop; an empty build
// goes from size straight to its single word. An ack steps through prepare, size,
// scan loop and drain (both skipped if nothing is scanned), then finish's summary.
// Results cannot be held off: strobe is a one-cycle pulse per word.
// Config writes (wr_en, wr_index, wr_data) take effect at once; issue them only
// while busy is low. Reset (rst, synchronous) clears the session: window 4,
// total 0, no resends, no stored frame.
module selective_repeat_sender_window import srsw_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  in_item_t               item,
  output logic                   strobe,
  output result_t                result,
  input  logic                   wr_en,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic [CFG_DATA_W-1:0]  wr_data
);

  ctrl_word_t ctrl;
  status_t    status;

  // Program sequencer
  srsw_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (item.command),
    .status  (status),
    .ctrl    (ctrl),
    .busy    (busy)
  );

  // Datapath
  srsw_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .item     (item),
    .op       (ctrl.op),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .status   (status),
    .strobe   (strobe),
    .result   (result)
  );

endmodule
